### sv/pip_pkg.sv
package pip_pkg;

	// coordinate format: signed, 8 fraction bits
	localparam int COORD_W      = 24;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// vertex storage depth and derived counter widths
	localparam int MAX_VERTICES = 64;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int STEP_W       = $clog2(MAX_VERTICES);

	// item selector codes
	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vertex_t;

	// one edge from vertex j (previous) to vertex i (current)
	typedef struct packed {
		logic    valid;
		vertex_t vi;
		vertex_t vj;
	} edge_req_t;

endpackage

### sv/pip_vertex_cell.sv
module pip_vertex_cell
	import pip_pkg::*;
(
	input  logic    clk,
	input  logic    shift_en,
	input  vertex_t vtx_in,
	output vertex_t vtx_out
);

	vertex_t vtx_q;

	// take the neighbour's vertex on each shift, otherwise hold
	always_ff @(posedge clk) begin
		if (shift_en) begin
			vtx_q <= vtx_in;
		end
	end

	assign vtx_out = vtx_q;

endmodule

### sv/pip_edge_test.sv
module pip_edge_test
	import pip_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  edge_req_t                 req,
	input  logic signed [COORD_W-1:0] px,
	input  logic signed [COORD_W-1:0] py,
	output logic                      parity
);

	logic                     valid_s1;
	logic                     straddle_s1;
	logic                     dyneg_s1;
	logic signed [DIFF_W-1:0] dxp_s1;
	logic signed [DIFF_W-1:0] dy_s1;
	logic signed [DIFF_W-1:0] dxe_s1;
	logic signed [DIFF_W-1:0] dyp_s1;

	logic                     valid_s2;
	logic                     straddle_s2;
	logic                     dyneg_s2;
	logic signed [PROD_W-1:0] lhs_s2;
	logic signed [PROD_W-1:0] rhs_s2;

	logic                     inside_q;
	logic                     left;

	// stage 1 and stage 2 control: edge valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: differences and straddle test
	always_ff @(posedge clk) begin
		straddle_s1 <= (req.vi.y > py) != (req.vj.y > py);
		dyneg_s1    <= req.vj.y < req.vi.y;
		dxp_s1      <= {px[COORD_W-1], px} - {req.vi.x[COORD_W-1], req.vi.x};
		dy_s1       <= {req.vj.y[COORD_W-1], req.vj.y} - {req.vi.y[COORD_W-1], req.vi.y};
		dxe_s1      <= {req.vj.x[COORD_W-1], req.vj.x} - {req.vi.x[COORD_W-1], req.vi.x};
		dyp_s1      <= {py[COORD_W-1], py} - {req.vi.y[COORD_W-1], req.vi.y};
	end

	// stage 2: cross products
	always_ff @(posedge clk) begin
		straddle_s2 <= straddle_s1;
		dyneg_s2    <= dyneg_s1;
		lhs_s2      <= PROD_W'(dxp_s1) * PROD_W'(dy_s1);
		rhs_s2      <= PROD_W'(dxe_s1) * PROD_W'(dyp_s1);
	end

	// point left of crossing, comparison flipped for downward edges
	assign left = dyneg_s2 ? (lhs_s2 > rhs_s2) : (lhs_s2 < rhs_s2);

	// toggle parity on each crossing; clear restarts it at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else if (clear) begin
			inside_q <= 1'b0;
		end else if (valid_s2 && straddle_s2 && left) begin
			inside_q <= !inside_q;
		end
	end

	assign parity = inside_q;

endmodule

### sv/point_in_polygon_test_core.sv
// Even-odd point-in-polygon test over a shifting row of vertex cells.
// Vertex words (start, append) keep the core idle, so it stays ready for more words.
// A query word rotates the row once, then tests the closing edge and drains the
// edge pipeline; the result waits in emit for a free output, then the core is ready.
// Reset (arst_n, asynchronous, active low) empties the polygon and clears overflow.
module point_in_polygon_test_core
	import pip_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [23:0] coord_x, [47:24] coord_y
	input  logic [1:0]  s_tuser,  // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] inside_res, [1] overflowed, [7:2] zero
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_CLOSE  = 6'b000100,
		ST_DRAIN1 = 6'b001000,
		ST_DRAIN2 = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic [STEP_W-1:0]         step_q;
	logic                      seen_q;
	vertex_t                   prev_q;
	vertex_t                   first_q;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;
	logic                      inside_res_q;
	logic                      overflowed_q;

	func_t                     func;
	vertex_t                   in_vtx;
	logic                      accept;
	logic                      room;
	logic                      store;
	logic                      shift_en;
	logic                      tail_valid;
	logic                      parity;
	logic                      out_free;
	vertex_t                   chain [MAX_VERTICES+1];
	edge_req_t                 req;

	assign func     = func_t'(s_tuser);
	assign in_vtx.x = s_tdata[COORD_W-1:0];
	assign in_vtx.y = s_tdata[2*COORD_W-1:COORD_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign room     = count_q < CNT_W'(MAX_VERTICES);
	assign store    = accept && ((func == FUNC_START) ||
		((func == FUNC_APPEND) && room));
	assign shift_en = store || (state_q == ST_WALK);
	assign out_free = !m_tvalid || m_tready;

	// feed the head cell: new vertex, or the tail word while rotating
	assign chain[0] = (state_q == ST_WALK) ? chain[MAX_VERTICES] : in_vtx;

	// vertex row: cell k holds vertex count-1-k
	genvar k;
	generate
		for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
			pip_vertex_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.vtx_in   (chain[k]),
				.vtx_out  (chain[k+1])
			);
		end
	endgenerate

	// tail word holds a stored vertex once the rotation reaches the filled cells
	assign tail_valid = ((CNT_W+1)'(step_q) + (CNT_W+1)'(count_q))
		>= (CNT_W+1)'(MAX_VERTICES);

	// build the edge request: consecutive pairs, then the closing edge
	always_comb begin
		req.valid = 1'b0;
		req.vi    = chain[MAX_VERTICES];
		req.vj    = prev_q;
		case (state_q)
			ST_WALK: begin
				req.valid = tail_valid && seen_q;
			end
			ST_CLOSE: begin
				req.valid = (count_q != '0);
				req.vi    = first_q;
			end
			default: begin
				req.valid = 1'b0;
			end
		endcase
	end

	pip_edge_test u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept && (func == FUNC_QUERY)),
		.req    (req),
		.px     (px_q),
		.py     (py_q),
		.parity (parity)
	);

	// polygon bookkeeping and query sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			step_q   <= '0;
			seen_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_START: begin
								count_q <= CNT_W'(1);
								ovf_q   <= 1'b0;
							end
							FUNC_APPEND: begin
								if (room) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							FUNC_QUERY: begin
								step_q  <= '0;
								seen_q  <= 1'b0;
								state_q <= ST_WALK;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					step_q <= step_q + STEP_W'(1);
					if (tail_valid) begin
						seen_q <= 1'b1;
					end
					if (step_q == STEP_W'(MAX_VERTICES - 1)) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					state_q <= ST_DRAIN1;
				end
				ST_DRAIN1: begin
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold query point, first and previous vertex of the walk
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_QUERY)) begin
			px_q <= in_vtx.x;
			py_q <= in_vtx.y;
		end
		if ((state_q == ST_WALK) && tail_valid) begin
			prev_q <= chain[MAX_VERTICES];
			if (!seen_q) begin
				first_q <= chain[MAX_VERTICES];
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			inside_res_q <= parity;
			overflowed_q <= ovf_q;
		end
	end

	assign m_tdata = {6'b0, overflowed_q, inside_res_q};

endmodule
